[rtl/core/prac_pkg.sv]
// Shared types, constants and lookup tables for the point rotation pipeline.
// Used by prac_front, prac_cell, prac_gain and point_rotation_about_center_top.
// No dependencies.
`default_nettype none

package prac_pkg;

    // Rotator datapath widths; fixed because the offset is always scaled to 2^36.
    localparam int VEC_W        = 39;
    localparam int ANG_W        = 32;
    localparam int ANG_IN_W     = 16;

    // Angle reduction and conversion to a binary angle.
    localparam int DEG_TURN     = 23040;
    localparam int RED_W        = 15;
    localparam int RECIP_45     = 46604;
    localparam int RECIP_SHIFT  = 21;
    localparam int PROD_A_W     = 31;
    localparam int K_W          = 9;
    localparam int R_W          = 6;
    localparam int TAB_W        = 23;
    localparam int DEG_STEP     = 45;

    // Gain correction (0.60725 in Q20), split into low and high partial products.
    localparam int GAIN_Q20     = 636751;
    localparam int GAIN_W       = 20;
    localparam int LO_W         = 20;
    localparam int PROD_W       = 60;
    localparam int SCALE_BITS   = 56;

    localparam int ATAN_TAB_LEN = 24;
    localparam int ATAN_IDX_W   = 5;

    // Quadrant taken off before the micro-rotations.
    typedef enum logic [1:0] {
        QUAD_0,
        QUAD_90,
        QUAD_180,
        QUAD_270
    } prac_quad_t;

    // Vector and residual angle handed from cell to cell.
    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [ANG_W-1:0] z;
    } prac_vec_t;

    // Arctangent of 2^-i as a fraction of a turn with 32 fraction bits.
    function automatic logic [ANG_W-1:0] prac_atan(input logic [ATAN_IDX_W-1:0] idx);
        logic [ANG_W-1:0] val;
        begin
            case (idx)
                5'd0:    val = 32'd536870912;
                5'd1:    val = 32'd316933406;
                5'd2:    val = 32'd167458907;
                5'd3:    val = 32'd85004756;
                5'd4:    val = 32'd42667331;
                5'd5:    val = 32'd21354465;
                5'd6:    val = 32'd10679838;
                5'd7:    val = 32'd5340245;
                5'd8:    val = 32'd2670163;
                5'd9:    val = 32'd1335087;
                5'd10:   val = 32'd667544;
                5'd11:   val = 32'd333772;
                5'd12:   val = 32'd166886;
                5'd13:   val = 32'd83443;
                5'd14:   val = 32'd41722;
                5'd15:   val = 32'd20861;
                5'd16:   val = 32'd10430;
                5'd17:   val = 32'd5215;
                5'd18:   val = 32'd2608;
                5'd19:   val = 32'd1304;
                5'd20:   val = 32'd652;
                5'd21:   val = 32'd326;
                5'd22:   val = 32'd163;
                5'd23:   val = 32'd81;
                default: val = '0;
            endcase
            return val;
        end
    endfunction

    // Turn fraction of r sixty-fourths of a degree step: (r * 2^23 + 22) / 45.
    function automatic logic [TAB_W-1:0] prac_frac_turn(input logic [R_W-1:0] r);
        logic [TAB_W-1:0] val;
        begin
            case (r)
                6'd0:    val = 23'd0;
                6'd1:    val = 23'd186414;
                6'd2:    val = 23'd372827;
                6'd3:    val = 23'd559241;
                6'd4:    val = 23'd745654;
                6'd5:    val = 23'd932068;
                6'd6:    val = 23'd1118481;
                6'd7:    val = 23'd1304895;
                6'd8:    val = 23'd1491308;
                6'd9:    val = 23'd1677722;
                6'd10:   val = 23'd1864135;
                6'd11:   val = 23'd2050549;
                6'd12:   val = 23'd2236962;
                6'd13:   val = 23'd2423376;
                6'd14:   val = 23'd2609789;
                6'd15:   val = 23'd2796203;
                6'd16:   val = 23'd2982616;
                6'd17:   val = 23'd3169030;
                6'd18:   val = 23'd3355443;
                6'd19:   val = 23'd3541857;
                6'd20:   val = 23'd3728270;
                6'd21:   val = 23'd3914684;
                6'd22:   val = 23'd4101097;
                6'd23:   val = 23'd4287511;
                6'd24:   val = 23'd4473924;
                6'd25:   val = 23'd4660338;
                6'd26:   val = 23'd4846751;
                6'd27:   val = 23'd5033165;
                6'd28:   val = 23'd5219578;
                6'd29:   val = 23'd5405992;
                6'd30:   val = 23'd5592405;
                6'd31:   val = 23'd5778819;
                6'd32:   val = 23'd5965232;
                6'd33:   val = 23'd6151646;
                6'd34:   val = 23'd6338059;
                6'd35:   val = 23'd6524473;
                6'd36:   val = 23'd6710886;
                6'd37:   val = 23'd6897300;
                6'd38:   val = 23'd7083713;
                6'd39:   val = 23'd7270127;
                6'd40:   val = 23'd7456540;
                6'd41:   val = 23'd7642954;
                6'd42:   val = 23'd7829367;
                6'd43:   val = 23'd8015781;
                6'd44:   val = 23'd8202194;
                default: val = '0;
            endcase
            return val;
        end
    endfunction

endpackage

`default_nettype wire

[rtl/core/prac_front.sv]
// Front end: offset from the centre, angle wrap and conversion to a binary
// angle, quadrant pre-rotation. Three registered stages. Depends on prac_pkg.
`default_nettype none

module prac_front
    import prac_pkg::*;
#(
    parameter int COORD_BITS = 16
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic signed [COORD_BITS-1:0] point_x,
    input  wire logic signed [COORD_BITS-1:0] point_y,
    input  wire logic signed [COORD_BITS-1:0] center_x,
    input  wire logic signed [COORD_BITS-1:0] center_y,
    input  wire logic signed [ANG_IN_W-1:0]   angle_deg,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output prac_vec_t                         out_vec
);

    localparam int OFS_W     = COORD_BITS + 1;
    localparam int FRAC_BITS = 36 - COORD_BITS;
    localparam int EXT_W     = VEC_W - OFS_W - FRAC_BITS;
    localparam int AEXT_W    = ANG_IN_W + 1;

    localparam logic signed [AEXT_W-1:0] TURN   = AEXT_W'(DEG_TURN);
    localparam logic signed [AEXT_W-1:0] TURN2  = AEXT_W'(2 * DEG_TURN);
    localparam logic signed [AEXT_W-1:0] NTURN  = -AEXT_W'(DEG_TURN);
    localparam logic [ANG_W-1:0]         HALF_Q = ANG_W'(1) << (ANG_W - 3);

    // Stage handshake.
    logic s1_ready, s2_ready, s3_ready;
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;

    // Stage payloads.
    logic signed [OFS_W-1:0]    s1_dx_reg, s1_dy_reg, s2_dx_reg, s2_dy_reg;
    logic        [RED_W-1:0]    s1_ang_reg;
    logic        [PROD_A_W-1:0] s1_prod_reg;
    logic        [K_W-1:0]      s2_k_reg;
    logic        [R_W-1:0]      s2_r_reg;
    prac_vec_t                  s3_vec_reg;

    // Combinational next values.
    logic signed [OFS_W-1:0]    dx_next, dy_next;
    logic signed [AEXT_W-1:0]   ang_ext, ang_wrap;
    logic        [RED_W-1:0]    ang_next;
    logic        [PROD_A_W-1:0] prod_next;
    logic        [K_W-1:0]      k_next;
    logic        [RED_W-1:0]    rem_full;
    logic        [R_W-1:0]      r_next;
    logic        [ANG_W-1:0]    turn_val, turn_rnd, z_val;
    prac_quad_t                 quad;
    logic signed [VEC_W-1:0]    x_pre, y_pre;
    prac_vec_t                  vec_next;

    assign s3_ready  = !s3_valid_reg || out_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign in_ready  = s1_ready;
    assign out_valid = s3_valid_reg;
    assign out_vec   = s3_vec_reg;

    // Offsets in the maths frame, angle wrapped into one turn, reciprocal product.
    always_comb
    begin
        dx_next = OFS_W'(point_x) - OFS_W'(center_x);
        dy_next = OFS_W'(center_y) - OFS_W'(point_y);
        ang_ext = AEXT_W'(angle_deg);
        if (ang_ext < NTURN)
        begin
            ang_wrap = ang_ext + TURN2;
        end
        else if (ang_ext < 0)
        begin
            ang_wrap = ang_ext + TURN;
        end
        else if (ang_ext >= TURN)
        begin
            ang_wrap = ang_ext - TURN;
        end
        else
        begin
            ang_wrap = ang_ext;
        end
        ang_next  = ang_wrap[RED_W-1:0];
        prod_next = PROD_A_W'(ang_next) * PROD_A_W'(RECIP_45);
    end

    // Whole steps of 45 sixty-fourths and the remainder.
    always_comb
    begin
        k_next   = s1_prod_reg[RECIP_SHIFT +: K_W];
        rem_full = s1_ang_reg - RED_W'(RED_W'(k_next) * RED_W'(DEG_STEP));
        r_next   = rem_full[R_W-1:0];
    end

    // Binary angle, nearest quadrant, residual and exact quarter-turn pre-rotation.
    always_comb
    begin
        turn_val = {s2_k_reg, prac_frac_turn(s2_r_reg)};
        turn_rnd = turn_val + HALF_Q;
        quad     = prac_quad_t'(turn_rnd[ANG_W-1 -: 2]);
        z_val    = turn_val - {turn_rnd[ANG_W-1 -: 2], {(ANG_W - 2){1'b0}}};
        x_pre    = {{EXT_W{s2_dx_reg[OFS_W-1]}}, s2_dx_reg, {FRAC_BITS{1'b0}}};
        y_pre    = {{EXT_W{s2_dy_reg[OFS_W-1]}}, s2_dy_reg, {FRAC_BITS{1'b0}}};
        vec_next.z = $signed(z_val);
        case (quad)
            QUAD_90:
            begin
                vec_next.x = -y_pre;
                vec_next.y = x_pre;
            end
            QUAD_180:
            begin
                vec_next.x = -x_pre;
                vec_next.y = -y_pre;
            end
            QUAD_270:
            begin
                vec_next.x = y_pre;
                vec_next.y = -x_pre;
            end
            default:
            begin
                vec_next.x = x_pre;
                vec_next.y = y_pre;
            end
        endcase
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Payload registers load only when a beat moves in.
    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_dx_reg   <= dx_next;
            s1_dy_reg   <= dy_next;
            s1_ang_reg  <= ang_next;
            s1_prod_reg <= prod_next;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_dx_reg <= s1_dx_reg;
            s2_dy_reg <= s1_dy_reg;
            s2_k_reg  <= k_next;
            s2_r_reg  <= r_next;
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_vec_reg <= vec_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/prac_cell.sv]
// One CORDIC micro-rotation cell: shift by its stage index, add or subtract,
// step the residual angle by the matching arctangent. Depends on prac_pkg.
`default_nettype none

module prac_cell
    import prac_pkg::*;
#(
    parameter int STAGE = 0
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire prac_vec_t in_vec,
    output logic           out_valid,
    input  wire logic      out_ready,
    output prac_vec_t      out_vec
);

    logic                    valid_reg;
    prac_vec_t               vec_reg;
    prac_vec_t               vec_next;
    logic signed [VEC_W-1:0] xs, ys;
    logic signed [ANG_W-1:0] step;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;

    // Micro-rotation in the direction that drives the residual angle to zero.
    always_comb
    begin
        xs   = in_vec.x >>> STAGE;
        ys   = in_vec.y >>> STAGE;
        step = $signed(prac_atan(ATAN_IDX_W'(STAGE)));
        if (!in_vec.z[ANG_W-1])
        begin
            vec_next.x = in_vec.x - ys;
            vec_next.y = in_vec.y + xs;
            vec_next.z = in_vec.z - step;
        end
        else
        begin
            vec_next.x = in_vec.x + ys;
            vec_next.y = in_vec.y - xs;
            vec_next.z = in_vec.z + step;
        end
    end

    // Valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            vec_reg <= vec_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/prac_gain.sv]
// Gain correction and output: split multiply by 0.60725, truncation toward
// zero, y flip back to the screen frame, output register. Depends on prac_pkg.
`default_nettype none

module prac_gain
    import prac_pkg::*;
#(
    parameter int COORD_BITS = 16
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire prac_vec_t                      in_vec,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic signed [COORD_BITS+1:0]        rotated_dx,
    output logic signed [COORD_BITS+1:0]        rotated_dy
);

    localparam int OUT_BITS = COORD_BITS + 2;
    localparam int SHIFT    = SCALE_BITS - COORD_BITS;
    localparam int HI_W     = VEC_W - LO_W;
    localparam int PL_W     = 2 * LO_W;
    localparam int PH_W     = HI_W + GAIN_W + 1;

    localparam logic [GAIN_W-1:0] GAIN = GAIN_W'(GAIN_Q20);
    localparam logic [PROD_W-1:0] BIAS = (PROD_W'(1) << SHIFT) - PROD_W'(1);

    logic p_ready, s_ready, t_ready, o_ready;
    logic p_valid_reg, s_valid_reg, t_valid_reg, o_valid_reg;

    logic        [PL_W-1:0]     pl_x_reg, pl_y_reg;
    logic signed [PH_W-1:0]     ph_x_reg, ph_y_reg;
    logic signed [PROD_W-1:0]   sum_x_reg, sum_y_reg;
    logic signed [OUT_BITS-1:0] tr_x_reg, tr_y_reg;
    logic signed [OUT_BITS-1:0] out_x_reg, out_y_reg;

    logic        [PL_W-1:0]     pl_x_next, pl_y_next;
    logic signed [PH_W-1:0]     ph_x_next, ph_y_next;
    logic signed [HI_W-1:0]     hi_x, hi_y;
    logic signed [PROD_W-1:0]   sum_x_next, sum_y_next;
    logic        [PROD_W-1:0]   bx, by;
    logic        [PROD_W-1:0]   vx, vy;

    assign o_ready   = !o_valid_reg || out_ready;
    assign t_ready   = !t_valid_reg || o_ready;
    assign s_ready   = !s_valid_reg || t_ready;
    assign p_ready   = !p_valid_reg || s_ready;
    assign in_ready  = p_ready;
    assign out_valid = o_valid_reg;
    assign rotated_dx = out_x_reg;
    assign rotated_dy = out_y_reg;

    // Partial products: unsigned low half and signed high half.
    always_comb
    begin
        hi_x      = in_vec.x[VEC_W-1:LO_W];
        hi_y      = in_vec.y[VEC_W-1:LO_W];
        pl_x_next = PL_W'(in_vec.x[LO_W-1:0]) * PL_W'(GAIN);
        pl_y_next = PL_W'(in_vec.y[LO_W-1:0]) * PL_W'(GAIN);
        ph_x_next = hi_x * $signed({1'b0, GAIN});
        ph_y_next = hi_y * $signed({1'b0, GAIN});
    end

    // Recombine the partial products.
    always_comb
    begin
        sum_x_next = $signed({ph_x_reg, {LO_W{1'b0}}}) + $signed({{(PROD_W - PL_W){1'b0}}, pl_x_reg});
        sum_y_next = $signed({ph_y_reg, {LO_W{1'b0}}}) + $signed({{(PROD_W - PL_W){1'b0}}, pl_y_reg});
    end

    // Truncation toward zero: bias negative values before the shift.
    always_comb
    begin
        bx = sum_x_reg[PROD_W-1] ? BIAS : '0;
        by = sum_y_reg[PROD_W-1] ? BIAS : '0;
        vx = sum_x_reg + bx;
        vy = sum_y_reg + by;
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
            t_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (p_ready)
            begin
                p_valid_reg <= in_valid;
            end
            if (s_ready)
            begin
                s_valid_reg <= p_valid_reg;
            end
            if (t_ready)
            begin
                t_valid_reg <= s_valid_reg;
            end
            if (o_ready)
            begin
                o_valid_reg <= t_valid_reg;
            end
        end
    end

    // Payloads; the output stage flips y back to the screen frame.
    always_ff @(posedge clk)
    begin
        if (p_ready && in_valid)
        begin
            pl_x_reg <= pl_x_next;
            pl_y_reg <= pl_y_next;
            ph_x_reg <= ph_x_next;
            ph_y_reg <= ph_y_next;
        end
        if (s_ready && p_valid_reg)
        begin
            sum_x_reg <= sum_x_next;
            sum_y_reg <= sum_y_next;
        end
        if (t_ready && s_valid_reg)
        begin
            tr_x_reg <= vx[SHIFT +: OUT_BITS];
            tr_y_reg <= vy[SHIFT +: OUT_BITS];
        end
        if (o_ready && t_valid_reg)
        begin
            out_x_reg <= tr_x_reg;
            out_y_reg <= -tr_y_reg;
        end
    end

endmodule

`default_nettype wire

[rtl/core/point_rotation_about_center_top.sv]
// Top level of the point rotator: front end, a chain of CORDIC cells and the
// gain/output stage. Depends on prac_pkg, prac_front, prac_cell, prac_gain.
//
//   Channel   Direction  Handshake           Beat contents
//   input     in         in_valid/in_ready   point_x, point_y, center_x, center_y, angle_deg
//   output    out        out_valid/out_ready rotated_dx, rotated_dy
//
// One beat is taken per clock unless a stall on out_ready has backed up; each beat passes through
// three front-end stages, one cell per micro-rotation, and four gain and output stages.
// Every stage has its own valid bit, so bubbles close up behind a stalled output.
// A stall on out_ready holds the results in place and backs up into in_ready.
// Reset clears only the valid bits; no state is kept between beats.
`default_nettype none

module point_rotation_about_center_top
    import prac_pkg::*;
#(
    parameter int COORD_BITS      = 16,
    parameter int ROTATION_STAGES = 18
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic signed [COORD_BITS-1:0] point_x,
    input  wire logic signed [COORD_BITS-1:0] point_y,
    input  wire logic signed [COORD_BITS-1:0] center_x,
    input  wire logic signed [COORD_BITS-1:0] center_y,
    input  wire logic signed [ANG_IN_W-1:0]   angle_deg,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic signed [COORD_BITS+1:0]      rotated_dx,
    output logic signed [COORD_BITS+1:0]      rotated_dy
);

    // Links between the front end, the cells and the gain stage.
    prac_vec_t chain_vec   [0:ROTATION_STAGES];
    logic      chain_valid [0:ROTATION_STAGES];
    logic      chain_ready [0:ROTATION_STAGES];

    prac_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .point_x   (point_x),
        .point_y   (point_y),
        .center_x  (center_x),
        .center_y  (center_y),
        .angle_deg (angle_deg),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_vec   (chain_vec[0])
    );

    // One cell per micro-rotation.
    for (genvar i = 0; i < ROTATION_STAGES; i++)
    begin : g_cell
        prac_cell #(
            .STAGE (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_vec    (chain_vec[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_vec   (chain_vec[i+1])
        );
    end

    prac_gain #(
        .COORD_BITS (COORD_BITS)
    ) u_gain (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (chain_valid[ROTATION_STAGES]),
        .in_ready   (chain_ready[ROTATION_STAGES]),
        .in_vec     (chain_vec[ROTATION_STAGES]),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .rotated_dx (rotated_dx),
        .rotated_dy (rotated_dy)
    );

endmodule

`default_nettype wire

[test/tb_top.sv]
// Self-checking testbench for the CORDIC point rotator about a centre.
// Depends on prac_pkg and point_rotation_about_center_top; uses nothing else.
// A bit-exact predictor feeds a queue of expected offsets; checked on each output beat.
`default_nettype none

module tb_top;
    import prac_pkg::*;

    localparam int COORD_BITS      = 16;
    localparam int ROTATION_STAGES = 18;
    localparam int OUT_W           = COORD_BITS + 2;
    localparam int FRAC_BITS       = 36 - COORD_BITS;
    localparam int LATENCY         = ROTATION_STAGES + 7;
    localparam int DRAIN_CYCLES    = 2 * LATENCY;
    localparam int STALL_LIMIT     = 2000;
    localparam int MAX_REPORTS     = 20;
    localparam int DEG_90          = 90 * 64;
    localparam int DEG_45          = 45 * 64;

    // Arctangent of 2^-i in fractions of a turn, 32 fraction bits.
    localparam longint ATAN_TURN [24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    typedef struct {
        logic [OUT_W-1:0] dx;
        logic [OUT_W-1:0] dy;
    } rot_offset_t;

    logic                           clk;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    logic                           in_ready;
    logic signed [COORD_BITS-1:0]   point_x   = '0;
    logic signed [COORD_BITS-1:0]   point_y   = '0;
    logic signed [COORD_BITS-1:0]   center_x  = '0;
    logic signed [COORD_BITS-1:0]   center_y  = '0;
    logic signed [ANG_IN_W-1:0]     angle_deg = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic signed [OUT_W-1:0]        rotated_dx;
    logic signed [OUT_W-1:0]        rotated_dy;

    rot_offset_t pending_offsets [$];
    int          send_idle_pct  = 0;
    int          sink_stall_pct = 0;
    int          points_sent    = 0;
    int          offsets_checked = 0;
    int          error_count    = 0;

    point_rotation_about_center_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .point_x    (point_x),
        .point_y    (point_y),
        .center_x   (center_x),
        .center_y   (center_y),
        .angle_deg  (angle_deg),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .rotated_dx (rotated_dx),
        .rotated_dy (rotated_dy)
    );

    // Clock with a period of 4.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Removes the CORDIC gain and truncates the magnitude toward zero.
    function automatic longint remove_gain(input longint v);
        longint p;
        begin
            p = v * GAIN_Q20;
            if (p < 0)
                return -((-p) >>> (FRAC_BITS + 20));
            return p >>> (FRAC_BITS + 20);
        end
    endfunction

    // Predicts the rotated offset of one point about its centre.
    function automatic rot_offset_t rotate_about_center(
        input logic signed [COORD_BITS-1:0] px,
        input logic signed [COORD_BITS-1:0] py,
        input logic signed [COORD_BITS-1:0] cx,
        input logic signed [COORD_BITS-1:0] cy,
        input logic signed [ANG_IN_W-1:0]   ang
    );
        longint      x;
        longint      y;
        longint      z;
        longint      a;
        longint      t;
        longint      tq;
        longint      xs;
        longint      ys;
        longint      tmp;
        longint      rx;
        longint      ry;
        prac_quad_t  quad;
        rot_offset_t res;
        begin
            // Offset from the centre in a math frame, y pointing up.
            x = (longint'(px) - longint'(cx)) * (longint'(1) <<< FRAC_BITS);
            y = (longint'(cy) - longint'(py)) * (longint'(1) <<< FRAC_BITS);

            // Wrap the angle into one turn and convert it to a binary angle.
            a = longint'(ang) % DEG_TURN;
            if (a < 0)
                a = a + DEG_TURN;
            t = (a * (longint'(1) <<< 23) + 22) / 45;

            // Take off the nearest quarter turn.
            tq   = t + (longint'(1) <<< 29);
            quad = prac_quad_t'(tq[31:30]);
            z    = t - (longint'(quad) <<< 30);
            if (z >= (longint'(1) <<< 31))
                z = z - (longint'(1) <<< 32);

            case (quad)
                QUAD_90:
                begin
                    tmp = x; x = -y; y = tmp;
                end
                QUAD_180:
                begin
                    x = -x; y = -y;
                end
                QUAD_270:
                begin
                    tmp = x; x = y; y = -tmp;
                end
                default: ;
            endcase

            // Micro-rotations with floor shifts.
            for (int i = 0; i < ROTATION_STAGES; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0)
                begin
                    x = x - ys;
                    y = y + xs;
                    z = z - ATAN_TURN[i];
                end
                else
                begin
                    x = x + ys;
                    y = y - xs;
                    z = z + ATAN_TURN[i];
                end
            end

            // Back to the screen frame.
            rx = remove_gain(x);
            ry = -remove_gain(y);
            res.dx = rx[OUT_W-1:0];
            res.dy = ry[OUT_W-1:0];
            return res;
        end
    endfunction

    // Sends one beat on the input channel, with random idle cycles ahead of it.
    task automatic send_point(
        input logic signed [COORD_BITS-1:0] px,
        input logic signed [COORD_BITS-1:0] py,
        input logic signed [COORD_BITS-1:0] cx,
        input logic signed [COORD_BITS-1:0] cy,
        input logic signed [ANG_IN_W-1:0]   ang
    );
        logic took;
        begin
            while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid  <= 1'b1;
            point_x   <= px;
            point_y   <= py;
            center_x  <= cx;
            center_y  <= cy;
            angle_deg <= ang;
            // The handshake is sampled mid-cycle, where everything is settled.
            do
            begin
                @(negedge clk);
                took = in_ready;
                if (took)
                begin
                    pending_offsets.push_back(rotate_about_center(px, py, cx, cy, ang));
                    points_sent++;
                end
                @(posedge clk);
            end
            while (!took);
        end
    endtask

    // Coordinate biased toward the extremes of the field.
    function automatic logic signed [COORD_BITS-1:0] pick_coord();
        begin
            case ($urandom_range(7))
                0:       return {1'b0, {(COORD_BITS-1){1'b1}}};
                1:       return {1'b1, {(COORD_BITS-1){1'b0}}};
                2:       return '0;
                default: return COORD_BITS'($urandom);
            endcase
        end
    endfunction

    // Angle within plus or minus one turn and one sixty-fourth of a degree.
    function automatic logic signed [ANG_IN_W-1:0] pick_angle();
        int a;
        begin
            case ($urandom_range(5))
                0:       a = (int'($urandom_range(16)) - 8) * DEG_45
                             + int'($urandom_range(2)) - 1;
                1:       a = ($urandom_range(1) != 0) ? DEG_TURN : -DEG_TURN;
                default: a = int'($urandom_range(2 * DEG_TURN)) - DEG_TURN;
            endcase
            return ANG_IN_W'(a);
        end
    endfunction

    // Extremes of every field, with the offset at its widest in both signs.
    task automatic test_field_extremes();
        begin
            send_point(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sd0);
            send_point(16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sd0);
            send_point(16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'(DEG_TURN));
            send_point(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'(-DEG_TURN));
            send_point(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'(DEG_45));
            send_point(16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'(-DEG_45 + 1));
            send_point(16'sh7fff, 16'sh7fff, 16'sh0000, 16'sh0000, 16'shffff);
            send_point(16'sh0000, 16'sh0000, 16'shffff, 16'shffff, 16'sd1);
        end
    endtask

    // Each quadrant, the boundaries between them, and angles wrapping past a turn.
    task automatic test_quadrants_and_wrap();
        begin
            send_point(16'sd1000, 16'sd200, 16'sd0, 16'sd0, 16'(DEG_90));
            send_point(16'sd1000, 16'sd200, 16'sd0, 16'sd0, 16'(2 * DEG_90));
            send_point(16'sd1000, 16'sd200, 16'sd0, 16'sd0, 16'(3 * DEG_90));
            send_point(16'sd1000, 16'sd200, 16'sd0, 16'sd0, 16'(DEG_45 - 1));
            send_point(16'sd1000, 16'sd200, 16'sd0, 16'sd0, 16'(3 * DEG_45));
            send_point(16'sd1000, 16'sd200, 16'sd0, 16'sd0, 16'(7 * DEG_45));
            send_point(-16'sd500, 16'sd321, 16'sd7, -16'sd9, 16'(-DEG_90));
            send_point(-16'sd500, 16'sd321, 16'sd7, -16'sd9, 16'(DEG_TURN - 1));
            send_point(-16'sd500, 16'sd321, 16'sd7, -16'sd9, 16'(-DEG_TURN + 1));
            send_point(-16'sd500, 16'sd321, 16'sd7, -16'sd9, 16'(DEG_TURN - DEG_45));
        end
    endtask

    // A point straight below its centre gets no extra half turn; a point on it stays put.
    task automatic test_below_and_on_center();
        begin
            send_point(16'sd100, 16'sd300, 16'sd100, 16'sd100, 16'(DEG_90));
            send_point(16'sd100, 16'sd300, 16'sd100, 16'sd100, 16'sd0);
            send_point(-16'sd40, 16'sh7fff, -16'sd40, 16'sh8000, 16'(DEG_45 + 7));
            send_point(16'sd55, 16'sd66, 16'sd55, 16'sd66, 16'(DEG_90 + 13));
            send_point(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'(-DEG_TURN));
        end
    endtask

    // Random points with the given idling on both sides.
    task automatic test_random_points(input int count, input int send_pct, input int sink_pct);
        logic signed [COORD_BITS-1:0] px;
        logic signed [COORD_BITS-1:0] py;
        logic signed [COORD_BITS-1:0] cx;
        logic signed [COORD_BITS-1:0] cy;
        begin
            send_idle_pct  = send_pct;
            sink_stall_pct = sink_pct;
            repeat (count)
            begin
                cx = pick_coord();
                cy = pick_coord();
                case ($urandom_range(7))
                    0:
                    begin
                        // Small offset close to the centre.
                        px = cx + COORD_BITS'(int'($urandom_range(16)) - 8);
                        py = cy + COORD_BITS'(int'($urandom_range(16)) - 8);
                    end
                    1:
                    begin
                        // Straight above or below the centre.
                        px = cx;
                        py = pick_coord();
                    end
                    2:
                    begin
                        px = cx;
                        py = cy;
                    end
                    default:
                    begin
                        px = pick_coord();
                        py = pick_coord();
                    end
                endcase
                send_point(px, py, cx, cy, pick_angle());
            end
        end
    endtask

    // Output stall pattern.
    initial
    begin
        forever
        begin
            @(posedge clk);
            out_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Compares each output beat with the oldest expected offset.
    initial
    begin
        rot_offset_t want;
        forever
        begin
            @(negedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                offsets_checked++;
                if (pending_offsets.size() == 0)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: unexpected beat dx=%0d dy=%0d",
                                 $time, rotated_dx, rotated_dy);
                end
                else
                begin
                    want = pending_offsets.pop_front();
                    if (rotated_dx !== want.dx)
                    begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                            $display("%0t: rotated_dx expected %0d, got %0d",
                                     $time, $signed(want.dx), rotated_dx);
                    end
                    if (rotated_dy !== want.dy)
                    begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                            $display("%0t: rotated_dy expected %0d, got %0d",
                                     $time, $signed(want.dy), rotated_dy);
                    end
                end
            end
        end
    end

    // Ends the run if no beat moves on either channel for too long.
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(negedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: timeout, %0d offsets still expected", $time, pending_offsets.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Test sequence.
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_field_extremes();
        test_quadrants_and_wrap();
        test_below_and_on_center();
        test_random_points(425, 0, 0);
        test_random_points(425, 86, 0);
        test_random_points(425, 0, 86);
        test_random_points(425, 30, 30);

        in_valid <= 1'b0;
        while (pending_offsets.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Rotated %0d points (field extremes, all quadrants, wrapped angles,", points_sent);
        $display("points below and on the centre, four idling mixes); %0d beats checked, %0d errors.",
                 offsets_checked, error_count);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
